[src/fal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fal_pkg: shared types for the fixed array list
// Request and response payloads, action codes and status codes.
// ----------------------------------------------------------------------------
package fal_pkg;

  typedef enum logic [2:0] {
    ACT_INS_FRONT  = 3'd0,
    ACT_INS_BACK   = 3'd1,
    ACT_REM_FRONT  = 3'd2,
    ACT_REM_BACK   = 3'd3,
    ACT_DROP_FRONT = 3'd4,
    ACT_DROP_BACK  = 3'd5,
    ACT_SEARCH     = 3'd6,
    ACT_READ       = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] value;
    logic        [4:0]  count;
    logic        [3:0]  position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               found;
    status_e            status;
    logic        [4:0]  length;
  } rsp_t;

endpackage
`default_nettype wire

[src/fal_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fal_mem: list entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fal_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic signed [31:0]       wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output      logic signed [31:0]       rdata_o
);

  logic signed [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/fal_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fal_ctrl: list sequencer
// Checks each request, walks the store through one read/write port pair to
// shift, search or fetch entries, and keeps the fill count.
// ----------------------------------------------------------------------------
module fal_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int FW    = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire fal_pkg::req_t       in_req_i,
  output      logic                idle_o,
  input  wire logic                slot_free_i,
  output      logic                done_o,
  output      fal_pkg::rsp_t       rsp_o,
  output      logic                mem_we_o,
  output      logic [AW-1:0]       mem_waddr_o,
  output      logic signed [31:0]  mem_wdata_o,
  output      logic                mem_re_o,
  output      logic [AW-1:0]       mem_raddr_o,
  input  wire logic signed [31:0]  mem_rdata_i
);
  import fal_pkg::*;

  localparam int CW = (FW > 5) ? FW : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_COPY,
    S_SEARCH,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  action_e            act_q, act_d;
  logic signed [31:0] value_q, value_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [FW-1:0]      left_q, left_d;
  logic [AW-1:0]      rd_q, rd_d;
  logic [AW-1:0]      wr_q, wr_d;
  logic               pend_q, pend_d;
  logic               dn_q, dn_d;
  logic signed [31:0] data_q, data_d;
  logic               found_q, found_d;
  status_e            status_q, status_d;

  logic full, empty;

  assign full   = (fill_q == FW'(DEPTH));
  assign empty  = (fill_q == '0);
  assign idle_o = (state_q == S_IDLE);
  assign rsp_o  = '{data: data_q, found: found_q, status: status_q, length: 5'(fill_q)};

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    value_d     = value_q;
    fill_d      = fill_q;
    left_d      = left_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pend_d      = pend_q;
    dn_d        = dn_q;
    data_d      = data_q;
    found_d     = found_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_q;
    done_o      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d    = in_req_i.action;
          value_d  = in_req_i.value;
          data_d   = '0;
          found_d  = 1'b0;
          status_d = ST_OK;
          pend_d   = 1'b0;
          dn_d     = 1'b0;
          left_d   = '0;
          state_d  = S_DONE;
          case (in_req_i.action)
            ACT_INS_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                // move entries up from the top down, then place the word at 0
                fill_d  = fill_q + 1'b1;
                rd_d    = AW'(fill_q - 1'b1);
                wr_d    = AW'(fill_q);
                left_d  = fill_q;
                dn_d    = 1'b1;
                state_d = S_COPY;
              end
            end
            ACT_INS_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(fill_q);
                mem_wdata_o = in_req_i.value;
                fill_d      = fill_q + 1'b1;
              end
            end
            ACT_REM_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                fill_d      = fill_q - 1'b1;
                rd_d        = AW'(1);
                wr_d        = '0;
                left_d      = fill_q - 1'b1;
                state_d     = S_FETCH;
              end
            end
            ACT_REM_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(fill_q - 1'b1);
                fill_d      = fill_q - 1'b1;
                state_d     = S_FETCH;
              end
            end
            ACT_DROP_FRONT, ACT_DROP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (CW'(in_req_i.count) > CW'(fill_q)) begin
                status_d = ST_RANGE;
              end else begin
                fill_d = fill_q - FW'(in_req_i.count);
                if (in_req_i.action == ACT_DROP_FRONT) begin
                  rd_d    = AW'(in_req_i.count);
                  wr_d    = '0;
                  left_d  = fill_q - FW'(in_req_i.count);
                  state_d = S_COPY;
                end
              end
            end
            ACT_SEARCH: begin
              rd_d    = '0;
              left_d  = fill_q;
              state_d = S_SEARCH;
            end
            ACT_READ: begin
              if (CW'(in_req_i.position) >= CW'(fill_q)) begin
                status_d = ST_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(in_req_i.position);
                state_d     = S_FETCH;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_FETCH: begin
        data_d  = mem_rdata_i;
        state_d = S_COPY;
      end

      S_COPY: begin
        if (left_q != '0) begin
          mem_re_o = 1'b1;
          rd_d     = dn_q ? rd_q - 1'b1 : rd_q + 1'b1;
          left_d   = left_q - 1'b1;
        end
        pend_d = (left_q != '0);
        if (pend_q) begin
          mem_we_o = 1'b1;
          wr_d     = dn_q ? wr_q - 1'b1 : wr_q + 1'b1;
        end
        if (left_q == '0 && !pend_q) begin
          if (act_q == ACT_INS_FRONT) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            mem_wdata_o = value_q;
          end
          state_d = S_DONE;
        end
      end

      S_SEARCH: begin
        if (left_q != '0) begin
          mem_re_o = 1'b1;
          rd_d     = rd_q + 1'b1;
          left_d   = left_q - 1'b1;
        end
        pend_d = (left_q != '0);
        if (pend_q && mem_rdata_i == value_q) begin
          found_d = 1'b1;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (left_q == '0 && !pend_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      left_q   <= '0;
      pend_q   <= 1'b0;
      act_q    <= ACT_INS_FRONT;
      value_q  <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      dn_q     <= 1'b0;
      data_q   <= '0;
      found_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      left_q   <= left_d;
      pend_q   <= pend_d;
      act_q    <= act_d;
      value_q  <= value_d;
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      dn_q     <= dn_d;
      data_q   <= data_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

endmodule
`default_nettype wire

[src/fixed_array_list.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: insert back, drop back and errors go straight to the response state;
//   remove back and read pass through a fetch of the addressed entry; shifts and
//   searches walk the list one entry per cycle through the single store port pair.
// Throughput: one request at a time; a new request is taken once the sequencer is idle,
//   even while the previous response still waits in the output register.
// Reset: the fill count and all control state clear; stored words stay undefined.
// ----------------------------------------------------------------------------
// fixed_array_list: bounded ordered list of signed 32-bit words
// Insert, remove, drop, search and indexed read over a store of DEPTH
// entries, walked one entry per cycle by a shared sequencer.
// ----------------------------------------------------------------------------
module fixed_array_list #(
  parameter int DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire fal_pkg::req_t  in_req_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      fal_pkg::rsp_t  out_rsp_o
);
  import fal_pkg::*;

  // store address and fill count widths
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic               idle;
  logic               slot_free;
  logic               done;
  rsp_t               rsp;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  logic               out_valid_q;
  rsp_t               out_rsp_q;

  // take a request only while the sequencer has nothing in flight
  assign in_ready_o = idle;

  // the output register can take a new response when empty or draining now
  assign slot_free = !out_valid_q || out_ready_i;

  fal_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .FW    (FW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .idle_o      (idle),
    .slot_free_i (slot_free),
    .done_o      (done),
    .rsp_o       (rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fal_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // hold the finished response until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload register: load on completion only
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
`default_nettype wire
